FILE: src/rbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    // default counter and length register width
    localparam int LEN_BITS_DEFAULT = 16;

    // output limit after reset, before masking to the counter width
    localparam int OUT_LIMIT_RESET = 4096;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT      = 1'd1;

    // decoder phase codes
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_HEADER  = 3'd0;
    localparam logic [PH_W-1:0] PH_VALUE   = 3'd1;
    localparam logic [PH_W-1:0] PH_LEN_HI  = 3'd2;
    localparam logic [PH_W-1:0] PH_LEN_LO  = 3'd3;
    localparam logic [PH_W-1:0] PH_LITERAL = 3'd4;
    localparam logic [PH_W-1:0] PH_DONE    = 3'd5;

    // end codes
    localparam logic [1:0] END_NONE = 2'd0;
    localparam logic [1:0] END_OK   = 2'd1;
    localparam logic [1:0] END_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_value;
        logic [7:0]  out_repeat;
        logic [1:0]  end_code;
        logic [15:0] out_total;
    } t_out_word;

endpackage

`default_nettype wire

FILE: src/rle_block_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                  | word
// ----------+-----------+----------------------------+------------------------------------
// input     | in        | i_in_valid / o_in_stall    | t_in_word: in_byte, first
// result    | out       | o_out_valid / i_out_stall  | t_out_word: value, repeat, end, total
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one compressed byte per cycle while no result stalls; a held byte is decoded once
// the result slot is free; its result loads into the result register at the next edge
// at most one result word per byte; bytes that give no result just update the state
// i_rst_n is synchronous: decoder back to expecting a header, both registers to defaults
// a stalled result holds the decode stage; the input register then raises o_in_stall
// o_in_stall follows i_out_stall in the same cycle, so a full pipe never loses a cycle

module rle_block_decoder #(
    parameter int LEN_BITS = rbd_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // compressed byte channel
    input  wire logic                          i_in_valid,
    input  wire rbd_pkg::t_in_word             i_in_word,
    output logic                               o_in_stall,
    // run descriptor channel
    output logic                               o_out_valid,
    output rbd_pkg::t_out_word                 o_out_word,
    input  wire logic                          i_out_stall,
    // register writes
    input  wire logic                          i_cfg_valid,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_BITS-1:0]           i_cfg_data,
    output logic                               o_cfg_ready
);
    import rbd_pkg::*;

    logic                r_in_valid;
    t_in_word            r_in_word;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic [LEN_BITS-1:0] compressed_length;
    logic [LEN_BITS-1:0] output_limit;
    logic                out_free;
    logic                advance;
    logic                res_valid;
    t_out_word           res_word;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    rbd_cfg_regs #(
        .LEN_BITS (LEN_BITS)
    ) u_cfg (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_compressed_length (compressed_length),
        .o_output_limit      (output_limit)
    );

    // result slot free when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    // the held byte is decoded whenever its result has somewhere to go
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    rbd_decode #(
        .LEN_BITS (LEN_BITS)
    ) u_decode (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (advance),
        .i_word              (r_in_word),
        .i_compressed_length (compressed_length),
        .i_output_limit      (output_limit),
        .o_res_valid         (res_valid),
        .o_res_word          (res_word)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: src/rbd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rbd_cfg_regs #(
    parameter int LEN_BITS = rbd_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_BITS-1:0]           i_cfg_data,
    output logic      [LEN_BITS-1:0]           o_compressed_length,
    output logic      [LEN_BITS-1:0]           o_output_limit
);
    import rbd_pkg::*;

    logic [LEN_BITS-1:0] r_compressed_length;
    logic [LEN_BITS-1:0] r_output_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed_length <= '0;
            r_output_limit      <= LEN_BITS'(OUT_LIMIT_RESET);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_COMPRESSED_LENGTH) begin
                r_compressed_length <= i_cfg_data;
            end
            if (i_cfg_index == CFG_OUTPUT_LIMIT) begin
                r_output_limit <= i_cfg_data;
            end
        end
    end

    assign o_compressed_length = r_compressed_length;
    assign o_output_limit      = r_output_limit;

endmodule

`default_nettype wire

FILE: src/rbd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module rbd_decode #(
    parameter int LEN_BITS = rbd_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire rbd_pkg::t_in_word   i_word,
    input  wire logic [LEN_BITS-1:0] i_compressed_length,
    input  wire logic [LEN_BITS-1:0] i_output_limit,
    output logic                     o_res_valid,
    output rbd_pkg::t_out_word       o_res_word
);
    import rbd_pkg::*;

    // compare width: holds any counter plus a 16-bit literal length without wrapping
    localparam int SW = ((LEN_BITS > 16) ? LEN_BITS : 16) + 1;

    logic [PH_W-1:0]     r_phase,    n_phase;
    logic [LEN_BITS-1:0] r_consumed, n_consumed;
    logic [LEN_BITS-1:0] r_written,  n_written;
    logic [LEN_BITS-1:0] r_lit_left, n_lit_left;
    logic [7:0]          r_pend_rep, n_pend_rep;
    logic [7:0]          r_len_high, n_len_high;

    // state as seen by this byte (a first-flagged byte restarts it)
    logic [PH_W-1:0]     ph;
    logic [LEN_BITS-1:0] cc, wc, ll;
    logic [7:0]          pr, lh, b;
    logic [LEN_BITS-1:0] cc1, wc1, ll1, wc_run;
    logic [SW-1:0]       cl_x, ol_x, cc_x, cc1_x, wc_x, len_x, run_sum;
    logic                budget, budget_run, budget_lit;
    logic [1:0]          code;

    always_comb begin
        ph = i_word.first ? PH_HEADER : r_phase;
        cc = i_word.first ? '0 : r_consumed;
        wc = i_word.first ? '0 : r_written;
        ll = i_word.first ? '0 : r_lit_left;
        pr = i_word.first ? 8'd0 : r_pend_rep;
        lh = i_word.first ? 8'd0 : r_len_high;
        b  = i_word.in_byte;

        cc1 = cc + LEN_BITS'(1);
        wc1 = wc + LEN_BITS'(1);
        ll1 = ll - LEN_BITS'(1);

        cl_x    = SW'(i_compressed_length);
        ol_x    = SW'(i_output_limit);
        cc_x    = SW'(cc);
        cc1_x   = SW'(cc1);
        wc_x    = SW'(wc);
        len_x   = SW'({lh, b});
        run_sum = wc_x + SW'(pr);
        wc_run  = run_sum[LEN_BITS-1:0];

        budget     = (cc_x >= cl_x) || (wc_x >= ol_x);
        budget_run = (cc1_x >= cl_x) || (SW'(wc_run) >= ol_x);
        budget_lit = (cc1_x >= cl_x) || (SW'(wc1) >= ol_x);

        n_phase    = ph;
        n_consumed = cc;
        n_written  = wc;
        n_lit_left = ll;
        n_pend_rep = pr;
        n_len_high = lh;

        o_res_valid          = 1'b0;
        code                 = END_NONE;
        o_res_word.out_value  = 8'd0;
        o_res_word.out_repeat = 8'd0;
        o_res_word.out_total  = wc_x[15:0];

        unique case (ph)
            PH_DONE: begin
                // ignore bytes until a restart
            end
            PH_HEADER: begin
                if (budget) begin
                    o_res_valid = 1'b1;
                    code        = END_OK;
                end else begin
                    n_consumed = cc1;
                    if (b == 8'd0) begin
                        if (cc1_x + SW'(1) >= cl_x) begin
                            o_res_valid = 1'b1;
                            code        = END_OK;
                        end else begin
                            n_phase = PH_LEN_HI;
                        end
                    end else if (cc1_x >= cl_x) begin
                        // repeat count with no room left for its value byte
                        o_res_valid = 1'b1;
                        code        = END_ERR;
                    end else begin
                        n_pend_rep = b;
                        n_phase    = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                n_consumed  = cc1;
                o_res_valid = 1'b1;
                if (run_sum > ol_x) begin
                    code = END_ERR;
                end else begin
                    n_written             = wc_run;
                    n_phase               = PH_HEADER;
                    o_res_word.out_value  = b;
                    o_res_word.out_repeat = pr;
                    o_res_word.out_total  = run_sum[15:0];
                    code                  = budget_run ? END_OK : END_NONE;
                end
            end
            PH_LEN_HI: begin
                n_consumed = cc1;
                n_len_high = b;
                n_phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_consumed = cc1;
                if (len_x == '0) begin
                    // terminator
                    o_res_valid = 1'b1;
                    code        = END_OK;
                end else if ((cc1_x + len_x > cl_x) || (wc_x + len_x > ol_x)) begin
                    o_res_valid = 1'b1;
                    code        = END_ERR;
                end else begin
                    n_lit_left = len_x[LEN_BITS-1:0];
                    n_phase    = (len_x[LEN_BITS-1:0] == '0) ? PH_HEADER : PH_LITERAL;
                end
            end
            default: begin
                // literal byte
                n_consumed            = cc1;
                n_written             = wc1;
                n_lit_left            = ll1;
                o_res_valid           = 1'b1;
                o_res_word.out_value  = b;
                o_res_word.out_repeat = 8'd1;
                o_res_word.out_total  = 16'(wc1);
                if (ll1 == '0) begin
                    n_phase = PH_HEADER;
                    code    = budget_lit ? END_OK : END_NONE;
                end
            end
        endcase

        if (code != END_NONE) begin
            n_phase = PH_DONE;
        end
        o_res_word.end_code = code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_consumed <= '0;
            r_written  <= '0;
            r_lit_left <= '0;
            r_pend_rep <= 8'd0;
            r_len_high <= 8'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_consumed <= n_consumed;
            r_written  <= n_written;
            r_lit_left <= n_lit_left;
            r_pend_rep <= n_pend_rep;
            r_len_high <= n_len_high;
        end
    end

endmodule

`default_nettype wire
